FILE: rtl/core/aubd_pkg.sv
// ----------------------------------------------------------------------------
// aubd_pkg
// Shared types, constants and helpers for the access unit boundary detector.
// ----------------------------------------------------------------------------
package aubd_pkg;

  localparam int POSITION_BITS_DEF = 32;

  localparam int BYTE_W     = 8;
  localparam int OUT_POS_W  = 32;
  localparam int NAL_TYPE_W = 6;
  localparam int SLICE_TYPE_W = 5;
  localparam int HIST_W     = 40;
  localparam int FILL_W     = 3;

  localparam logic [FILL_W-1:0] FILL_MAX        = 3'd5;
  localparam logic [FILL_W-1:0] FILL_FOR_CODE   = 3'd4;
  localparam logic [FILL_W-1:0] FILL_FOR_PREV   = 3'd5;

  localparam logic [31:0] START_CODE_MASK = 32'hffffff00;
  localparam logic [31:0] START_CODE      = 32'h00000100;

  // types below this one are VCL
  localparam logic [NAL_TYPE_W-1:0] VCL_TYPE_LIMIT = 6'd32;

  // slice byte arrives two bytes after the first header byte
  localparam logic [1:0] SLICE_WAIT = 2'd2;

  typedef struct packed {
    logic                    hit;
    logic [OUT_POS_W-1:0]    unit_start;
    logic [OUT_POS_W-1:0]    slice_pos;
    logic [SLICE_TYPE_W-1:0] slice_type;
  } aubd_result_t;

  // aud, vps, sps, pps, prefix sei and the reserved and unspecified ranges that open an access unit
  function automatic logic marks_candidate(input logic [NAL_TYPE_W-1:0] t);
    return t inside {6'd32, 6'd33, 6'd34, 6'd35, 6'd39, [6'd41:6'd44], [6'd48:6'd55]};
  endfunction

endpackage

FILE: rtl/core/aubd_if.sv
// ----------------------------------------------------------------------------
// aubd channel interfaces
// Byte input channel and access unit result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface aubd_byte_if;
  logic                        valid;
  logic                        ready;
  logic [aubd_pkg::BYTE_W-1:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface aubd_unit_if;
  logic                              valid;
  logic                              ready;
  logic [aubd_pkg::OUT_POS_W-1:0]    unit_start_position;
  logic [aubd_pkg::OUT_POS_W-1:0]    first_slice_position;
  logic [aubd_pkg::SLICE_TYPE_W-1:0] first_slice_type;

  modport source (output valid, output unit_start_position, output first_slice_position,
                  output first_slice_type, input ready);
  modport sink (input valid, input unit_start_position, input first_slice_position,
                input first_slice_type, output ready);
endinterface

FILE: rtl/core/hevc_access_unit_boundary_detector.sv
// ----------------------------------------------------------------------------
// hevc_access_unit_boundary_detector
// Finds access unit starts in an H.265 Annex B byte stream.
// ----------------------------------------------------------------------------
// in_stream takes one stream byte per word. out_unit gives one word per access
// unit, on the first slice byte of its first slice segment: where the access
// unit begins (one byte earlier when a zero byte leads the start code), where
// the first slice's start code sits, and that slice's NAL unit type.
// Positions count bytes from reset and wrap at 2^POSITION_BITS; the low 32
// bits are reported.
// A byte is held in an input register, then scanned against the stream state
// and the result lands in the output register. One byte per cycle is taken
// while out_unit keeps up; the single scan stage and its state registers
// set that rate. Reset clears the byte history, the position counter and
// any held candidate or pending slice. When out_unit stalls with a word
// waiting, the scan stage holds, one more byte waits in the input register,
// then in_stream.ready drops.
// ----------------------------------------------------------------------------
module hevc_access_unit_boundary_detector #(
  parameter int POSITION_BITS = aubd_pkg::POSITION_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  aubd_byte_if.sink   in_stream,
  aubd_unit_if.source out_unit
);

  logic                        byte_vld_r;
  logic [aubd_pkg::BYTE_W-1:0] byte_r;
  logic                        advance;
  aubd_pkg::aubd_result_t      scan_res;

  logic                              out_vld_r;
  logic [aubd_pkg::OUT_POS_W-1:0]    unit_start_r;
  logic [aubd_pkg::OUT_POS_W-1:0]    slice_pos_r;
  logic [aubd_pkg::SLICE_TYPE_W-1:0] slice_type_r;

  // scan only when the output register is free or being emptied
  assign advance         = byte_vld_r && (!out_vld_r || out_unit.ready);
  assign in_stream.ready = !byte_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else if (in_stream.ready) begin
      byte_vld_r <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.ready && in_stream.valid) begin
      byte_r <= in_stream.stream_byte;
    end
  end

  aubd_scan #(
    .POSITION_BITS (POSITION_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .byte_in (byte_r),
    .result  (scan_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= scan_res.hit;
    end else if (out_unit.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && scan_res.hit) begin
      unit_start_r <= scan_res.unit_start;
      slice_pos_r  <= scan_res.slice_pos;
      slice_type_r <= scan_res.slice_type;
    end
  end

  assign out_unit.valid                = out_vld_r;
  assign out_unit.unit_start_position  = unit_start_r;
  assign out_unit.first_slice_position = slice_pos_r;
  assign out_unit.first_slice_type     = slice_type_r;

endmodule

FILE: rtl/core/aubd_scan.sv
// ----------------------------------------------------------------------------
// aubd_scan
// Start code scanner and access unit state; one byte per step, result is
// combinational on the stepped byte.
// ----------------------------------------------------------------------------
module aubd_scan #(
  parameter int POSITION_BITS = aubd_pkg::POSITION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [aubd_pkg::BYTE_W-1:0] byte_in,
  output aubd_pkg::aubd_result_t      result
);

  localparam int ExtW = (POSITION_BITS > aubd_pkg::OUT_POS_W) ? POSITION_BITS
                                                              : aubd_pkg::OUT_POS_W;

  logic [aubd_pkg::HIST_W-1:0]       hist_r, hist_nxt;
  logic [aubd_pkg::FILL_W-1:0]       fill_r, fill_nxt;
  logic [POSITION_BITS-1:0]          pos_r, pos_nxt;
  logic                              cand_held_r, cand_held_nxt;
  logic [POSITION_BITS-1:0]          cand_start_r, cand_start_nxt;
  logic                              pend_r, pend_nxt;
  logic [aubd_pkg::SLICE_TYPE_W-1:0] pend_type_r, pend_type_nxt;
  logic [POSITION_BITS-1:0]          pend_pos_r, pend_pos_nxt;
  logic [1:0]                        pend_cnt_r, pend_cnt_nxt;
  logic                              pend_pz_r, pend_pz_nxt;

  logic                              code_seen;
  logic                              prev_zero;
  logic [aubd_pkg::NAL_TYPE_W-1:0]   nal_type;
  logic [POSITION_BITS-1:0]          code_pos;
  logic [POSITION_BITS-1:0]          code_adj;
  logic [POSITION_BITS-1:0]          pend_adj;
  logic [POSITION_BITS-1:0]          start_sel;
  logic [ExtW-1:0]                   start_ext;
  logic [ExtW-1:0]                   slice_ext;

  assign hist_nxt = {hist_r[aubd_pkg::HIST_W-aubd_pkg::BYTE_W-1:0], byte_in};
  assign fill_nxt = (fill_r < aubd_pkg::FILL_MAX) ? fill_r + 3'd1 : fill_r;
  assign pos_nxt  = pos_r + POSITION_BITS'(1);

  // header byte is the newest byte, start code sits in the three before it
  assign code_seen = (fill_nxt >= aubd_pkg::FILL_FOR_CODE) &&
                     ((hist_nxt[31:0] & aubd_pkg::START_CODE_MASK) == aubd_pkg::START_CODE);
  assign nal_type  = hist_nxt[aubd_pkg::NAL_TYPE_W:1];
  assign prev_zero = (fill_nxt >= aubd_pkg::FILL_FOR_PREV) && (hist_nxt[39:32] == 8'd0);
  assign code_pos  = pos_r - POSITION_BITS'(3);
  assign code_adj  = prev_zero ? code_pos - POSITION_BITS'(1) : code_pos;
  assign pend_adj  = pend_pz_r ? pend_pos_r - POSITION_BITS'(1) : pend_pos_r;
  assign start_sel = cand_held_r ? cand_start_r : pend_adj;
  assign start_ext = ExtW'(start_sel);
  assign slice_ext = ExtW'(pend_pos_r);

  always_comb begin
    cand_held_nxt  = cand_held_r;
    cand_start_nxt = cand_start_r;
    pend_nxt       = pend_r;
    pend_type_nxt  = pend_type_r;
    pend_pos_nxt   = pend_pos_r;
    pend_cnt_nxt   = pend_cnt_r;
    pend_pz_nxt    = pend_pz_r;

    result.hit        = 1'b0;
    result.unit_start = start_ext[aubd_pkg::OUT_POS_W-1:0];
    result.slice_pos  = slice_ext[aubd_pkg::OUT_POS_W-1:0];
    result.slice_type = pend_type_r;

    if (pend_r) begin
      if (pend_cnt_r > 2'd1) begin
        pend_cnt_nxt = pend_cnt_r - 2'd1;
      end else begin
        pend_cnt_nxt  = 2'd0;
        pend_nxt      = 1'b0;
        // first_slice_segment_in_pic_flag
        result.hit    = step && byte_in[7];
        cand_held_nxt = 1'b0;
      end
    end

    if (code_seen) begin
      if (nal_type < aubd_pkg::VCL_TYPE_LIMIT) begin
        pend_nxt      = 1'b1;
        pend_type_nxt = nal_type[aubd_pkg::SLICE_TYPE_W-1:0];
        pend_pos_nxt  = code_pos;
        pend_cnt_nxt  = aubd_pkg::SLICE_WAIT;
        pend_pz_nxt   = prev_zero;
      end else if (aubd_pkg::marks_candidate(nal_type) && !cand_held_nxt) begin
        cand_held_nxt  = 1'b1;
        cand_start_nxt = code_adj;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r       <= '0;
      fill_r       <= '0;
      pos_r        <= '0;
      cand_held_r  <= 1'b0;
      cand_start_r <= '0;
      pend_r       <= 1'b0;
      pend_type_r  <= '0;
      pend_pos_r   <= '0;
      pend_cnt_r   <= '0;
      pend_pz_r    <= 1'b0;
    end else if (step) begin
      hist_r       <= hist_nxt;
      fill_r       <= fill_nxt;
      pos_r        <= pos_nxt;
      cand_held_r  <= cand_held_nxt;
      cand_start_r <= cand_start_nxt;
      pend_r       <= pend_nxt;
      pend_type_r  <= pend_type_nxt;
      pend_pos_r   <= pend_pos_nxt;
      pend_cnt_r   <= pend_cnt_nxt;
      pend_pz_r    <= pend_pz_nxt;
    end
  end

endmodule

FILE: dv/tb_hevc_access_unit_boundary_detector.sv
// ----------------------------------------------------------------------------
// tb_hevc_access_unit_boundary_detector
// Feeds Annex B byte streams through the access unit boundary detector and
// checks every result word against a scan model kept in step with the
// accepted bytes. Covers directed NAL sequences, random access units with
// noise and broken start codes, output backpressure and filler runs.
// ----------------------------------------------------------------------------
module tb_hevc_access_unit_boundary_detector;
  timeunit 1ns;
  timeprecision 1ps;

  // position counter narrower than the 32-bit reported positions
  localparam int POS_BITS       = 16;
  localparam int RANDOM_BYTES   = 1400;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_REPORTS    = 10;

  localparam logic [5:0] NAL_TRAIL_R     = 6'd1;
  localparam logic [5:0] NAL_IDR_W_RADL  = 6'd19;
  localparam logic [5:0] NAL_CRA         = 6'd21;
  localparam logic [5:0] NAL_VPS         = 6'd32;
  localparam logic [5:0] NAL_SPS         = 6'd33;
  localparam logic [5:0] NAL_PPS         = 6'd34;
  localparam logic [5:0] NAL_AUD         = 6'd35;
  localparam logic [5:0] NAL_EOS         = 6'd36;
  localparam logic [5:0] NAL_EOB         = 6'd37;
  localparam logic [5:0] NAL_FD          = 6'd38;
  localparam logic [5:0] NAL_PREFIX_SEI  = 6'd39;
  localparam logic [5:0] NAL_SUFFIX_SEI  = 6'd40;
  localparam logic [5:0] NAL_RSV_41      = 6'd41;
  localparam logic [5:0] NAL_RSV_44      = 6'd44;
  localparam logic [5:0] NAL_RSV_45      = 6'd45;
  localparam logic [5:0] NAL_UNSPEC_48   = 6'd48;
  localparam logic [5:0] NAL_UNSPEC_55   = 6'd55;
  localparam logic [5:0] NAL_UNSPEC_56   = 6'd56;

  typedef enum {SINK_FREE, SINK_COIN, SINK_BEAT, SINK_SLOW} sink_mode_t;

  typedef struct {
    logic [aubd_pkg::OUT_POS_W-1:0]    unit_start;
    logic [aubd_pkg::OUT_POS_W-1:0]    slice_pos;
    logic [aubd_pkg::SLICE_TYPE_W-1:0] slice_type;
  } unit_word_t;

  typedef logic [7:0] byte_seq_t[$];

  logic clk = 1'b0;
  logic rst_n;

  aubd_byte_if byte_ch ();
  aubd_unit_if unit_ch ();

  hevc_access_unit_boundary_detector #(
    .POSITION_BITS(POS_BITS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_stream(byte_ch),
    .out_unit (unit_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scan model state, all zero out of reset
  logic [aubd_pkg::HIST_W-1:0]       scan_hist     = '0;
  logic [aubd_pkg::FILL_W-1:0]       scan_fill     = '0;
  logic [POS_BITS-1:0]               scan_pos      = '0;
  bit                                cand_held     = 1'b0;
  logic [POS_BITS-1:0]               cand_start    = '0;
  bit                                slice_due     = 1'b0;
  logic [aubd_pkg::SLICE_TYPE_W-1:0] due_type      = '0;
  logic [POS_BITS-1:0]               due_code_pos  = '0;
  logic [1:0]                        due_count     = '0;
  bit                                due_lead_zero = 1'b0;

  unit_word_t  units_due[$];
  int unsigned mismatch_count = 0;
  int unsigned bytes_sent     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned burst_left     = 0;
  bit          gaps_on        = 1'b1;
  bit          offering       = 1'b0;
  bit          hold_request   = 1'b0;

  function automatic logic [POS_BITS-1:0] step_back(input logic [POS_BITS-1:0] pos,
                                                    input bit lead_zero);
    return lead_zero ? pos - 1'b1 : pos;
  endfunction

  function automatic bit opens_unit(input logic [5:0] t);
    return t == NAL_VPS || t == NAL_SPS || t == NAL_PPS || t == NAL_AUD ||
           t == NAL_PREFIX_SEI || (t >= NAL_RSV_41 && t <= NAL_RSV_44) ||
           (t >= NAL_UNSPEC_48 && t <= NAL_UNSPEC_55);
  endfunction

  // advance the scan by one byte, queue the word it produces if any
  function automatic void scan_byte(input logic [7:0] b);
    logic [POS_BITS-1:0] here;
    logic [POS_BITS-1:0] code_pos;
    logic [5:0]          nal_type;
    bit                  lead_zero;
    unit_word_t          w;
    here = scan_pos;
    scan_hist = {scan_hist[31:0], b};
    if (scan_fill < aubd_pkg::FILL_MAX) scan_fill = scan_fill + 1'b1;
    scan_pos = scan_pos + 1'b1;
    if (slice_due) begin
      if (due_count > 2'd1) begin
        due_count = due_count - 1'b1;
      end else begin
        due_count = '0;
        slice_due = 1'b0;
        // first_slice_segment_in_pic_flag
        if (b[7]) begin
          w.unit_start = 32'(cand_held ? cand_start : step_back(due_code_pos, due_lead_zero));
          w.slice_pos  = 32'(due_code_pos);
          w.slice_type = due_type;
          units_due.push_back(w);
        end
        cand_held = 1'b0;
      end
    end
    if (scan_fill >= aubd_pkg::FILL_FOR_CODE &&
        (scan_hist[31:0] & aubd_pkg::START_CODE_MASK) == aubd_pkg::START_CODE) begin
      nal_type  = scan_hist[6:1];
      code_pos  = here - 2'd3;
      lead_zero = scan_fill >= aubd_pkg::FILL_FOR_PREV && scan_hist[39:32] == 8'h00;
      if (nal_type < aubd_pkg::VCL_TYPE_LIMIT) begin
        slice_due     = 1'b1;
        due_type      = nal_type[4:0];
        due_code_pos  = code_pos;
        due_count     = aubd_pkg::SLICE_WAIT;
        due_lead_zero = lead_zero;
      end else if (opens_unit(nal_type) && !cand_held) begin
        cand_held  = 1'b1;
        cand_start = step_back(code_pos, lead_zero);
      end
    end
  endfunction

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
  endfunction

  // result checker
  always @(posedge clk) begin
    unit_word_t want;
    if (rst_n === 1'b1 && unit_ch.valid === 1'b1 && unit_ch.ready === 1'b1) begin
      if (units_due.size() == 0) begin
        note_mismatch($sformatf("word with none due: start %h slice %h type %0d",
                                unit_ch.unit_start_position, unit_ch.first_slice_position,
                                unit_ch.first_slice_type));
      end else begin
        want = units_due.pop_front();
        if (unit_ch.unit_start_position !== want.unit_start)
          note_mismatch($sformatf("unit_start_position expected %h got %h",
                                  want.unit_start, unit_ch.unit_start_position));
        if (unit_ch.first_slice_position !== want.slice_pos)
          note_mismatch($sformatf("first_slice_position expected %h got %h",
                                  want.slice_pos, unit_ch.first_slice_position));
        if (unit_ch.first_slice_type !== want.slice_type)
          note_mismatch($sformatf("first_slice_type expected %0d got %0d",
                                  want.slice_type, unit_ch.first_slice_type));
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((byte_ch.valid && byte_ch.ready) === 1'b1 || (unit_ch.valid && unit_ch.ready) === 1'b1)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver pacing, plus one long hold-off on request
  initial begin : sink_pacing
    sink_mode_t  mode;
    int unsigned mode_left;
    int unsigned beat;
    mode = SINK_FREE;
    mode_left = 0;
    beat = 0;
    unit_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        unit_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = sink_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        beat++;
        case (mode)
          SINK_FREE: unit_ch.ready <= 1'b1;
          SINK_COIN: unit_ch.ready <= 1'($urandom_range(0, 1));
          SINK_BEAT: unit_ch.ready <= (beat % 4 == 0);
          default:   unit_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // sender bursts with random gaps between them
  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = gaps_on ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
        byte_ch.valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    byte_ch.valid <= 1'b1;
    byte_ch.stream_byte <= b;
    offering = 1'b1;
    do @(posedge clk); while (byte_ch.ready !== 1'b1);
    bytes_sent++;
    scan_byte(b);
    pace();
  endtask

  task automatic send_bytes(input byte_seq_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  function automatic logic [7:0] payload_byte();
    return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
  endfunction

  // one NAL unit: optional leading zero, start code, two header bytes,
  // slice byte for VCL types, then payload
  task automatic send_nal(input logic [5:0] nal_type, input bit lead_zero,
                          input bit first_slice, input int unsigned payload_len);
    if (lead_zero) send_byte(8'h00);
    send_bytes('{8'h00, 8'h00, 8'h01});
    send_byte({1'($urandom), nal_type, 1'($urandom)});
    send_byte(8'($urandom));
    if (nal_type < aubd_pkg::VCL_TYPE_LIMIT) send_byte({first_slice, 7'($urandom)});
    repeat (payload_len) send_byte(payload_byte());
  endtask

  function automatic logic [5:0] pick_opener_type();
    case ($urandom_range(0, 6))
      0:       return NAL_VPS;
      1:       return NAL_SPS;
      2:       return NAL_PPS;
      3:       return NAL_AUD;
      4:       return NAL_PREFIX_SEI;
      5:       return NAL_RSV_41 + 6'($urandom_range(0, 3));
      default: return NAL_UNSPEC_48 + 6'($urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [5:0] pick_inert_type();
    case ($urandom_range(0, 5))
      0:       return NAL_EOS;
      1:       return NAL_EOB;
      2:       return NAL_FD;
      3:       return NAL_SUFFIX_SEI;
      4:       return NAL_RSV_45 + 6'($urandom_range(0, 2));
      default: return NAL_UNSPEC_56 + 6'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic send_access_unit();
    int unsigned n_open;
    int unsigned n_slices;
    bit          first;
    n_open = $urandom_range(0, 4);
    repeat (n_open) send_nal(pick_opener_type(), 1'($urandom), 1'b0, $urandom_range(0, 6));
    if ($urandom_range(0, 4) == 0)
      send_nal(pick_inert_type(), 1'($urandom), 1'b0, $urandom_range(0, 4));
    n_slices = $urandom_range(1, 3);
    for (int i = 0; i < n_slices; i++) begin
      first = (i == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 7) == 0);
      send_nal(6'($urandom_range(0, 31)), 1'($urandom), first, $urandom_range(0, 8));
    end
  endtask

  task automatic send_noise();
    int unsigned len;
    len = $urandom_range(1, 16);
    repeat (len) send_byte(payload_byte());
  endtask

  task automatic send_broken_unit();
    case ($urandom_range(0, 2))
      // near-miss start codes
      0: send_bytes('{8'h00, 8'h00, 8'($urandom_range(2, 255)), 8'h00, 8'h00, 8'h00});
      // vcl header cut short by the next start code
      1: begin
        send_bytes('{8'h00, 8'h00, 8'h01, {1'b0, 6'($urandom_range(0, 31)), 1'b0}});
        send_nal(6'($urandom), 1'($urandom), 1'($urandom), $urandom_range(0, 3));
      end
      // openers followed by a slice that is not first
      default: begin
        send_nal(pick_opener_type(), 1'($urandom), 1'b0, $urandom_range(0, 3));
        send_nal(6'($urandom_range(0, 31)), 1'($urandom), 1'b0, $urandom_range(0, 3));
      end
    endcase
  endtask

  task automatic test_stream_start();
    // start code at position zero, nothing before it in the history
    send_nal(NAL_VPS, 1'b0, 1'b0, 1);
    send_nal(NAL_IDR_W_RADL, 1'b1, 1'b1, 0);
  endtask

  task automatic test_special_units();
    // leading zero before the aud, a second opener keeps the first candidate
    send_nal(NAL_AUD, 1'b1, 1'b0, 1);
    send_nal(NAL_SPS, 1'b0, 1'b0, 2);
    send_bytes('{8'h00, 8'h00, 8'h01, {1'b0, NAL_CRA, 1'b0}, 8'h01, 8'hff});
    // a slice that is not first drops the candidate
    send_nal(NAL_PPS, 1'b0, 1'b0, 1);
    send_bytes('{8'h00, 8'h00, 8'h01, {1'b0, NAL_TRAIL_R, 1'b0}, 8'h01, 8'h7f});
    send_nal(NAL_IDR_W_RADL, 1'b1, 1'b1, 0);
    // inert type holds nothing
    send_nal(NAL_EOS, 1'b0, 1'b0, 0);
    // both header bytes zero
    send_bytes('{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h80});
    // start codes overlapping the bytes of a pending slice
    send_bytes('{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, {1'b0, NAL_VPS, 1'b0}, 8'h01});
    send_bytes('{8'h00, 8'h00, 8'h01, {1'b0, NAL_TRAIL_R, 1'b0}, 8'h00, 8'h00, 8'h01,
                 {1'b0, NAL_IDR_W_RADL, 1'b0}, 8'h01, 8'h80});
  endtask

  task automatic test_random_stream();
    int unsigned stop_at;
    int unsigned pick;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 7) send_access_unit();
      else if (pick == 7) send_noise();
      else if (pick == 8) send_broken_unit();
      else send_nal(6'($urandom), 1'($urandom), 1'($urandom), $urandom_range(0, 6));
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    hold_request = 1'b1;
    repeat (6) begin
      send_nal(NAL_AUD, 1'b0, 1'b0, 0);
      send_nal(NAL_CRA, 1'b0, 1'b1, 1);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_filler_units();
    gaps_on = 1'b0;
    send_nal(NAL_TRAIL_R, 1'b0, 1'b0, 0);
    send_bytes('{8'h00, 8'h00, 8'h01, {1'b0, NAL_FD, 1'b0}, 8'h01});
    // filler run, then a unit whose leading zero follows it
    repeat (8) send_byte(8'hff);
    send_nal(NAL_AUD, 1'b1, 1'b0, 1);
    send_nal(NAL_CRA, 1'b0, 1'b1, 3);
    gaps_on = 1'b1;
    repeat (4) send_access_unit();
  endtask

  initial begin : run
    rst_n = 1'b0;
    byte_ch.valid <= 1'b0;
    byte_ch.stream_byte <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_stream_start();
    test_special_units();
    test_random_stream();
    test_backpressure();
    test_filler_units();
    if (offering) byte_ch.valid <= 1'b0;
    while (units_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
